### rtl/sarg_pkg.sv
// ----------------------------------------------------------------------------
// sarg_pkg: shared types and constants of the servo angle ramp generator
// Widths, register indexes, queue item, divider request/response, back FSM.
// ----------------------------------------------------------------------------
package sarg_pkg;

  localparam int CHANNELS    = 2;
  localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd2;

  localparam logic [7:0] MAX_ANGLE_RST = 8'd180;
  localparam logic [8:0] SPEED_RST     = 9'd60;
  localparam logic [7:0] STEP_SIZE_RST = 8'd3;

  localparam logic [7:0] MAX_ANGLE_LO = 8'd1;
  localparam logic [7:0] MAX_ANGLE_HI = 8'd180;
  localparam logic [8:0] SPEED_LO     = 9'd1;
  localparam logic [8:0] SPEED_HI     = 9'd360;
  localparam logic [7:0] STEP_SIZE_LO = 8'd3;
  localparam logic [7:0] STEP_SIZE_HI = 8'd180;

  localparam int TGT_W   = 13;
  localparam int ANG_W   = 12;
  localparam int HOLD_W  = 18;
  localparam int STEPS_W = 6;

  localparam logic [ANG_W-1:0] SMALL_MOVE = 12'd8;
  localparam int MS_PER_S = 1000;

  // mag * 1000 < 2^22, 16 * speed < 2^13
  localparam int DIV_N_W = 22;
  localparam int DIV_D_W = 13;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [ANG_W-1:0]   max_ang16;  // clamp limit in 1/16 degree
    logic [DIV_D_W-1:0] speed16;
    logic [ANG_W-1:0]   step16;
  } cfg_t;

  typedef struct packed {
    logic                ch_field;
    logic [CH_IDX_W-1:0] ch_idx;
    logic [ANG_W-1:0]    tgt;
  } item_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_N_W-1:0] quotient;
    logic [DIV_D_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_STEPS,
    S_DIV_TIME,
    S_DIV_DELAY,
    S_DIV_INC,
    S_STEP,
    S_FINAL
  } back_state_e;

endpackage

### rtl/sarg_front.sv
// ----------------------------------------------------------------------------
// sarg_front: input stage
// Takes items, clamps the target, maps the channel and holds it for the queue.
// ----------------------------------------------------------------------------
module sarg_front import sarg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    channel_i,
  input  logic signed [TGT_W-1:0] target_angle_i,
  output logic                    push_o,
  output item_t                   push_item_o,
  input  logic                    push_ready_i
);

  logic  st_valid_q, st_valid_d;
  item_t st_item_q;
  item_t clamp_item;
  logic  accept;

  always_comb begin
    clamp_item.ch_field = channel_i;
    clamp_item.ch_idx   = CH_IDX_W'((CHANNELS > 1) ? channel_i : 1'b0);
    if (target_angle_i[TGT_W-1]) begin
      clamp_item.tgt = '0;
    end else if (target_angle_i[ANG_W-1:0] > cfg_i.max_ang16) begin
      clamp_item.tgt = cfg_i.max_ang16;
    end else begin
      clamp_item.tgt = target_angle_i[ANG_W-1:0];
    end
  end

  assign in_ready_o = !st_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = st_valid_q;
  assign push_item_o = st_item_q;

  always_comb begin
    st_valid_d = st_valid_q;
    if (accept) begin
      st_valid_d = 1'b1;
    end else if (push_ready_i) begin
      st_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else begin
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_item_q <= clamp_item;
    end
  end

endmodule

### rtl/sarg_queue.sv
// ----------------------------------------------------------------------------
// sarg_queue: short item queue
// Decouples the input stage from the ramp sequencer.
// ----------------------------------------------------------------------------
module sarg_queue import sarg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output item_t pop_item_o,
  input  logic  pop_i
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue overfilled");

endmodule

### rtl/sarg_div.sv
// ----------------------------------------------------------------------------
// sarg_div: shared restoring divider
// One quotient bit per cycle; done pulses once quotient and remainder settle.
// ----------------------------------------------------------------------------
module sarg_div import sarg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_N_W-1:0]   quo_q;
  logic [DIV_D_W-1:0]   rem_q;
  logic [DIV_D_W-1:0]   dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_D_W:0]     rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q, quo_q[DIV_N_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_N_W-2:0], ge};
      rem_q <= ge ? DIV_D_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIV_D_W-1:0];
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

### rtl/sarg_back.sv
// ----------------------------------------------------------------------------
// sarg_back: ramp sequencer
// Holds per-channel angles, sizes the ramp through the divider, emits steps.
// ----------------------------------------------------------------------------
module sarg_back import sarg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              pop_valid_i,
  input  item_t             pop_item_i,
  output logic              pop_o,
  output div_req_t          div_req_o,
  input  div_rsp_t          div_rsp_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_channel_o,
  output logic [ANG_W-1:0]  angle_o,
  output logic [HOLD_W-1:0] hold_ms_o,
  output logic              last_o
);

  back_state_e state_q, state_d;

  logic [ANG_W-1:0]    cur_q [CHANNELS];
  logic                ch_field_q;
  logic [CH_IDX_W-1:0] ch_idx_q;
  logic [ANG_W-1:0]    tgt_q, base_q, mag_q;
  logic                up_q;
  logic [STEPS_W-1:0]  steps_q, k_q, racc_q, rm_q;
  logic [HOLD_W-1:0]   delay_q;
  logic [ANG_W-1:0]    qm_q, acc_q;

  logic                out_valid_q, out_last_q, out_ch_q;
  logic [ANG_W-1:0]    out_angle_q;
  logic [HOLD_W-1:0]   out_hold_q;

  logic [ANG_W-1:0]    head_cur, head_mag;
  logic                head_up;
  logic                ld;
  logic [STEPS_W:0]    r_sum;
  logic                carry;
  logic [STEPS_W-1:0]  r_next;
  logic [ANG_W-1:0]    acc_next, step_angle;
  logic [STEPS_W-1:0]  div_steps;

  assign head_cur = cur_q[pop_item_i.ch_idx];
  assign head_up  = pop_item_i.tgt >= head_cur;
  assign head_mag = head_up ? pop_item_i.tgt - head_cur : head_cur - pop_item_i.tgt;

  assign ld = !out_valid_q || out_ready_i;

  // running offset mag*k/steps as quotient plus remainder
  assign r_sum    = {1'b0, racc_q} + {1'b0, rm_q};
  assign carry    = r_sum >= {1'b0, steps_q};
  assign r_next   = carry ? STEPS_W'(r_sum - {1'b0, steps_q}) : r_sum[STEPS_W-1:0];
  assign acc_next = acc_q + qm_q + ANG_W'(carry);
  assign step_angle = up_q ? base_q + acc_next : base_q - acc_next;

  assign div_steps = (div_rsp_i.quotient == '0) ? STEPS_W'(1)
                                                : div_rsp_i.quotient[STEPS_W-1:0];

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_req_o = '{start: 1'b0, dividend: '0, divisor: '0};
    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          pop_o = 1'b1;
          if (head_mag >= SMALL_MOVE) begin
            div_req_o = '{start: 1'b1, dividend: DIV_N_W'(head_mag),
                          divisor: DIV_D_W'(cfg_i.step16)};
            state_d = S_DIV_STEPS;
          end
        end
      end
      S_DIV_STEPS: begin
        if (div_rsp_i.done) begin
          div_req_o = '{start: 1'b1,
                        dividend: DIV_N_W'(mag_q) * DIV_N_W'(MS_PER_S),
                        divisor: cfg_i.speed16};
          state_d = S_DIV_TIME;
        end
      end
      S_DIV_TIME: begin
        if (div_rsp_i.done) begin
          div_req_o = '{start: 1'b1, dividend: div_rsp_i.quotient,
                        divisor: DIV_D_W'(steps_q)};
          state_d = S_DIV_DELAY;
        end
      end
      S_DIV_DELAY: begin
        if (div_rsp_i.done) begin
          div_req_o = '{start: 1'b1, dividend: DIV_N_W'(mag_q),
                        divisor: DIV_D_W'(steps_q)};
          state_d = S_DIV_INC;
        end
      end
      S_DIV_INC: begin
        if (div_rsp_i.done) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (ld && (k_q + 1'b1 == steps_q)) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        if (ld) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        cur_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (ld) begin
        out_valid_q <= (state_q == S_STEP) || (state_q == S_FINAL);
      end
      if (state_q == S_FINAL && ld) begin
        cur_q[ch_idx_q] <= tgt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          ch_field_q <= pop_item_i.ch_field;
          ch_idx_q   <= pop_item_i.ch_idx;
          tgt_q      <= pop_item_i.tgt;
          base_q     <= head_cur;
          up_q       <= head_up;
          mag_q      <= head_mag;
        end
      end
      S_DIV_STEPS: begin
        if (div_rsp_i.done) begin
          steps_q <= div_steps;
        end
      end
      S_DIV_DELAY: begin
        if (div_rsp_i.done) begin
          delay_q <= div_rsp_i.quotient[HOLD_W-1:0];
        end
      end
      S_DIV_INC: begin
        if (div_rsp_i.done) begin
          qm_q   <= div_rsp_i.quotient[ANG_W-1:0];
          rm_q   <= div_rsp_i.remainder[STEPS_W-1:0];
          acc_q  <= '0;
          racc_q <= '0;
          k_q    <= '0;
        end
      end
      S_STEP: begin
        if (ld) begin
          acc_q       <= acc_next;
          racc_q      <= r_next;
          k_q         <= k_q + 1'b1;
          out_ch_q    <= ch_field_q;
          out_angle_q <= step_angle;
          out_hold_q  <= delay_q;
          out_last_q  <= 1'b0;
        end
      end
      S_FINAL: begin
        if (ld) begin
          out_ch_q    <= ch_field_q;
          out_angle_q <= tgt_q;
          out_hold_q  <= '0;
          out_last_q  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign angle_o       = out_angle_q;
  assign hold_ms_o     = out_hold_q;
  assign last_o        = out_last_q;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (k_q < steps_q) && (racc_q < steps_q))
    else $error("step counter or remainder out of range");

  a_no_small_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_STEPS) |-> (mag_q >= SMALL_MOVE))
    else $error("ramp started for a small move");

  a_final_updates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL && ld) |=> (cur_q[ch_idx_q] == tgt_q) && out_last_q)
    else $error("channel angle not updated on final write");

endmodule

### rtl/servo_angle_ramp_generator_core.sv
// ----------------------------------------------------------------------------
// servo_angle_ramp_generator_core: linear slew-rate ramp for servo channels
// Config registers, input stage, item queue, shared divider and sequencer.
// ----------------------------------------------------------------------------
// Sequencing: an accepted item passes through four sequential divisions on
//   the one shared divider before its first result.
// Throughput: then one result per cycle while taken; a move under half a
//   degree skips the divisions and emits no result.
// Reset: registers to 180 deg / 60 deg/s / 3 deg, every channel angle zero,
//   queue and output empty.
module servo_angle_ramp_generator_core import sarg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    channel_i,
  input  logic signed [TGT_W-1:0] target_angle_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    out_channel_o,
  output logic [ANG_W-1:0]        angle_o,
  output logic [HOLD_W-1:0]       hold_ms_o,
  output logic                    last_o
);

  logic [7:0] max_angle_q, step_size_q;
  logic [8:0] speed_q;
  logic [7:0] max_sat, step_sat;
  logic [8:0] speed_sat;
  cfg_t       cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_angle_q <= MAX_ANGLE_RST;
      speed_q     <= SPEED_RST;
      step_size_q <= STEP_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_ANGLE: max_angle_q <= cfg_data_i[7:0];
        REG_SPEED:     speed_q     <= cfg_data_i;
        REG_STEP_SIZE: step_size_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // registers are saturated into range before use
  assign max_sat   = (max_angle_q < MAX_ANGLE_LO) ? MAX_ANGLE_LO :
                     (max_angle_q > MAX_ANGLE_HI) ? MAX_ANGLE_HI : max_angle_q;
  assign speed_sat = (speed_q < SPEED_LO) ? SPEED_LO :
                     (speed_q > SPEED_HI) ? SPEED_HI : speed_q;
  assign step_sat  = (step_size_q < STEP_SIZE_LO) ? STEP_SIZE_LO :
                     (step_size_q > STEP_SIZE_HI) ? STEP_SIZE_HI : step_size_q;

  assign cfg.max_ang16 = {max_sat, 4'b0000};
  assign cfg.speed16   = {speed_sat, 4'b0000};
  assign cfg.step16    = {step_sat, 4'b0000};

  logic     push, push_ready, pop_valid, pop;
  item_t    push_item, pop_item;
  div_req_t div_req;
  div_rsp_t div_rsp;

  sarg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .channel_i      (channel_i),
    .target_angle_i (target_angle_i),
    .push_o         (push),
    .push_item_o    (push_item),
    .push_ready_i   (push_ready)
  );

  sarg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_i        (pop)
  );

  sarg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sarg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .pop_valid_i   (pop_valid),
    .pop_item_i    (pop_item),
    .pop_o         (pop),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_channel_o (out_channel_o),
    .angle_o       (angle_o),
    .hold_ms_o     (hold_ms_o),
    .last_o        (last_o)
  );

endmodule
